>>> design/gsbp_pkg.sv
// ============================================================================
// gsbp_pkg - shared definitions for the gshare / btb branch predictor
// Widths, stream packing sizes, item kinds and the btb entry layout.
// ============================================================================
package gsbp_pkg;

    localparam int PC_W              = 64;
    localparam int CTR_W             = 2;
    localparam int IDX_LSB           = 2;   // instructions are word aligned

    localparam int BTB_ENTRIES_DEF   = 1024;
    localparam int PHT_ENTRIES_DEF   = 256;
    localparam int HISTORY_BITS_DEF  = 8;

    // slave tdata: pc, actual_next_pc, predicted_next_pc, four flags
    localparam int S_FIELDS_W        = 3 * PC_W + 4;
    localparam int S_TDATA_W         = ((S_FIELDS_W + 7) / 8) * 8;
    // master tdata: next_pc, mispredict, btb_hit, predict_taken
    localparam int M_FIELDS_W        = PC_W + 3;
    localparam int M_TDATA_W         = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [PC_W-1:0] PC_STEP = PC_W'(4);

    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_RESOLVE = 1'b1
    } opcode_t;

    typedef logic [CTR_W-1:0] ctr_t;

    typedef struct packed {
        logic            valid;
        logic            cond;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
    } btb_line_t;

endpackage

>>> design/gsbp_btb.sv
// ============================================================================
// gsbp_btb - branch target buffer storage
// Direct-mapped entry memory, one write and one registered read per cycle,
// with write data forwarded to a read of the same entry in the same cycle.
// ============================================================================
module gsbp_btb #(
    parameter int  ENTRIES = gsbp_pkg::BTB_ENTRIES_DEF,
    localparam int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                   aclk,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_idx,
    output gsbp_pkg::btb_line_t    rd_data,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_idx,
    input  gsbp_pkg::btb_line_t    wr_data
);
    import gsbp_pkg::*;

    btb_line_t btb_mem [ENTRIES];
    btb_line_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            btb_mem[wr_idx] <= wr_data;
        end
    end

    // same-entry write wins so the reader sees the newest contents
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= (wr_en && (wr_idx == rd_idx)) ? wr_data : btb_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/gsbp_pht.sv
// ============================================================================
// gsbp_pht - pattern history table
// Two-bit counter memory, one write and one registered read per cycle,
// with write data forwarded to a read of the same counter in the same cycle.
// ============================================================================
module gsbp_pht #(
    parameter int  ENTRIES = gsbp_pkg::PHT_ENTRIES_DEF,
    localparam int IDX_W   = $clog2(ENTRIES)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output gsbp_pkg::ctr_t    rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  gsbp_pkg::ctr_t    wr_data
);
    import gsbp_pkg::*;

    ctr_t pht_mem [ENTRIES];
    ctr_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pht_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= (wr_en && (wr_idx == rd_idx)) ? wr_data : pht_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/gshare_btb_branch_predictor.sv
// ============================================================================
// gshare_btb_branch_predictor - gshare direction predictor with a btb
// an accepted word passes the memory read (stage 1) and the result reg before m_tvalid
// throughput: one word per cycle unless the result side or the reset sweep stalls;
// predict and resolve words freely mixed. reset: sync active-low; clears history,
// then sweeps btb valid bits and counters over max(BTB_ENTRIES, PHT_ENTRIES)
// entries (1024 by default), with s_tready low for the whole sweep
// ============================================================================
module gshare_btb_branch_predictor #(
    parameter int BTB_ENTRIES  = gsbp_pkg::BTB_ENTRIES_DEF,   // power of two
    parameter int PHT_ENTRIES  = gsbp_pkg::PHT_ENTRIES_DEF,   // power of two
    parameter int HISTORY_BITS = gsbp_pkg::HISTORY_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] pc, [127:64] actual_next_pc, [191:128] predicted_next_pc,
    // [192] is_conditional, [193] taken, [194] predicted_taken,
    // [195] fetch_btb_hit, [199:196] zero
    input  logic [gsbp_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] opcode: 0 predict, 1 resolve
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] next_pc, [64] mispredict, [65] btb_hit, [66] predict_taken,
    // [71:67] zero
    output logic [gsbp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import gsbp_pkg::*;

    localparam int BTB_IDX_W = $clog2(BTB_ENTRIES);
    localparam int PHT_IDX_W = $clog2(PHT_ENTRIES);
    localparam int CLR_DEPTH = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
    localparam int CLR_IDX_W = $clog2(CLR_DEPTH);
    localparam int M_PAD_W   = M_TDATA_W - M_FIELDS_W;

    // saturating two-bit counter step
    function automatic ctr_t ctr_update(input ctr_t c, input logic up);
        ctr_t r;
        r = c;
        if (up) begin
            if (c != '1) r = c + ctr_t'(1);
        end else begin
            if (c != '0) r = c - ctr_t'(1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input word fields
    // ------------------------------------------------------------------
    opcode_t          in_op;
    logic [PC_W-1:0]  in_pc;
    logic [PC_W-1:0]  in_actual;
    logic [PC_W-1:0]  in_pred_pc;
    logic             in_cond;
    logic             in_taken;
    logic             in_pred_taken;
    logic             in_fetch_hit;

    assign in_op         = opcode_t'(s_tuser);
    assign in_pc         = s_tdata[0 +: PC_W];
    assign in_actual     = s_tdata[PC_W +: PC_W];
    assign in_pred_pc    = s_tdata[2*PC_W +: PC_W];
    assign in_cond       = s_tdata[3*PC_W];
    assign in_taken      = s_tdata[3*PC_W + 1];
    assign in_pred_taken = s_tdata[3*PC_W + 2];
    assign in_fetch_hit  = s_tdata[3*PC_W + 3];

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic                     clr_active_reg;
    logic [CLR_IDX_W-1:0]     clr_idx_reg;
    logic [HISTORY_BITS-1:0]  hist_reg;
    logic [HISTORY_BITS-1:0]  hist_next;

    // stage 1: captured word, memory read data arrives alongside
    logic                     s1_valid_reg;
    opcode_t                  s1_op_reg;
    logic [PC_W-1:0]          s1_pc_reg;
    logic [PC_W-1:0]          s1_actual_reg;
    logic [PC_W-1:0]          s1_pred_pc_reg;
    logic                     s1_cond_reg;
    logic                     s1_taken_reg;
    logic                     s1_pred_taken_reg;
    logic                     s1_fetch_hit_reg;
    logic [PHT_IDX_W-1:0]     s1_pht_idx_reg;

    // result register
    logic                     m_valid_reg;
    logic [PC_W-1:0]          m_next_pc_reg;
    logic                     m_mispredict_reg;
    logic                     m_btb_hit_reg;
    logic                     m_pred_taken_reg;

    // ------------------------------------------------------------------
    // flow control: stage 1 moves when the result register is free
    // ------------------------------------------------------------------
    logic out_free;
    logic s1_adv;
    logic in_acc;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !clr_active_reg && (!s1_valid_reg || out_free);
    assign in_acc   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    btb_line_t             btb_rd;
    logic                  btb_wr_en;
    logic [BTB_IDX_W-1:0]  btb_wr_idx;
    btb_line_t             btb_wr_data;
    logic [BTB_IDX_W-1:0]  btb_rd_idx;

    ctr_t                  pht_rd;
    logic                  pht_wr_en;
    logic [PHT_IDX_W-1:0]  pht_wr_idx;
    ctr_t                  pht_wr_data;
    logic [PHT_IDX_W-1:0]  pht_rd_idx;

    logic is_resolve;
    logic btb_train;
    logic pht_train;

    assign is_resolve = (s1_op_reg == OP_RESOLVE);
    assign btb_train  = s1_adv && is_resolve && s1_taken_reg;
    assign pht_train  = s1_adv && is_resolve && s1_cond_reg;

    // history after the word leaving stage 1; the word entering now indexes
    // the counters with it, so back-to-back resolves see each other
    assign hist_next = pht_train ? {hist_reg[HISTORY_BITS-2:0], s1_taken_reg} : hist_reg;

    assign btb_rd_idx = in_pc[IDX_LSB +: BTB_IDX_W];
    assign pht_rd_idx = in_pc[IDX_LSB +: PHT_IDX_W] ^ PHT_IDX_W'(hist_next);

    // clearing sweep and training share the write ports
    always_comb begin
        btb_wr_en   = clr_active_reg || btb_train;
        btb_wr_idx  = s1_pc_reg[IDX_LSB +: BTB_IDX_W];
        btb_wr_data = '{valid: 1'b1, cond: s1_cond_reg, tag: s1_pc_reg,
                        target: s1_actual_reg};
        pht_wr_en   = clr_active_reg || pht_train;
        pht_wr_idx  = s1_pht_idx_reg;
        pht_wr_data = ctr_update(pht_rd, s1_taken_reg);
        if (clr_active_reg) begin
            btb_wr_idx  = clr_idx_reg[BTB_IDX_W-1:0];
            btb_wr_data = '0;
            pht_wr_idx  = clr_idx_reg[PHT_IDX_W-1:0];
            pht_wr_data = '0;
        end
    end

    gsbp_btb #(
        .ENTRIES (BTB_ENTRIES)
    ) u_btb (
        .aclk    (aclk),
        .rd_en   (in_acc),
        .rd_idx  (btb_rd_idx),
        .rd_data (btb_rd),
        .wr_en   (btb_wr_en),
        .wr_idx  (btb_wr_idx),
        .wr_data (btb_wr_data)
    );

    gsbp_pht #(
        .ENTRIES (PHT_ENTRIES)
    ) u_pht (
        .aclk    (aclk),
        .rd_en   (in_acc),
        .rd_idx  (pht_rd_idx),
        .rd_data (pht_rd),
        .wr_en   (pht_wr_en),
        .wr_idx  (pht_wr_idx),
        .wr_data (pht_wr_data)
    );

    // ------------------------------------------------------------------
    // stage 1 result logic
    // ------------------------------------------------------------------
    logic            hit;
    logic            use_target;
    logic            miss;
    logic [PC_W-1:0] res_next_pc;

    assign hit        = btb_rd.valid && (btb_rd.tag == s1_pc_reg);
    // unconditional hits always redirect, conditional ones need taken counter
    assign use_target = hit && (!btb_rd.cond || pht_rd[CTR_W-1]);
    assign miss       = (s1_actual_reg != s1_pred_pc_reg)
                     || (s1_pred_taken_reg != s1_taken_reg)
                     || (s1_taken_reg && !s1_fetch_hit_reg);
    assign res_next_pc = is_resolve ? s1_actual_reg
                       : (use_target ? btb_rd.target : s1_pc_reg + PC_STEP);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            hist_reg       <= '0;
        end else begin
            hist_reg <= hist_next;
            if (clr_active_reg) begin
                clr_idx_reg <= clr_idx_reg + CLR_IDX_W'(1);
                if (clr_idx_reg == CLR_IDX_W'(CLR_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= in_acc || (s1_valid_reg && !out_free);
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_op_reg         <= in_op;
            s1_pc_reg         <= in_pc;
            s1_actual_reg     <= in_actual;
            s1_pred_pc_reg    <= in_pred_pc;
            s1_cond_reg       <= in_cond;
            s1_taken_reg      <= in_taken;
            s1_pred_taken_reg <= in_pred_taken;
            s1_fetch_hit_reg  <= in_fetch_hit;
            s1_pht_idx_reg    <= pht_rd_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_next_pc_reg    <= res_next_pc;
            m_mispredict_reg <= is_resolve && miss;
            m_btb_hit_reg    <= !is_resolve && hit;
            m_pred_taken_reg <= !is_resolve && use_target;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_pred_taken_reg, m_btb_hit_reg,
                       m_mispredict_reg, m_next_pc_reg};

endmodule

>>> sim/gsbp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// gsbp_checker - outcome checker for the gshare / btb branch predictor
// Mirrors the btb, the counter table and the history, works out the outcome
// of every accepted input word and compares result words in order.
// ============================================================================
module gsbp_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [63:0] pc, [127:64] actual_next_pc, [191:128] predicted_next_pc,
    // [192] is_conditional, [193] taken, [194] predicted_taken,
    // [195] fetch_btb_hit, [199:196] zero
    input  logic [gsbp_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [63:0] next_pc, [64] mispredict, [65] btb_hit, [66] predict_taken,
    // [71:67] zero
    input  logic [gsbp_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             pending
);
    import gsbp_pkg::*;

    localparam int BTB_IW   = $clog2(BTB_ENTRIES_DEF);
    localparam int PHT_IW   = $clog2(PHT_ENTRIES_DEF);
    localparam int HIST_W   = HISTORY_BITS_DEF;
    localparam int SHOWN    = 10;
    localparam ctr_t CTR_MAX   = 2'b11;
    localparam ctr_t CTR_TAKEN = 2'b10;   // weakly taken and above

    typedef struct packed {
        logic            fetch_hit;
        logic            pred_taken;
        logic            taken;
        logic            cond;
        logic [PC_W-1:0] predicted;
        logic [PC_W-1:0] actual;
        logic [PC_W-1:0] pc;
    } branch_word_t;

    typedef struct packed {
        logic            use_target;
        logic            hit;
        logic            mispredict;
        logic [PC_W-1:0] next_pc;
    } outcome_t;

    btb_line_t         btb [BTB_ENTRIES_DEF];
    ctr_t              pht [PHT_ENTRIES_DEF];
    logic [HIST_W-1:0] ghist;
    outcome_t          outcome_q[$];

    task automatic predict_outcome(input opcode_t op, input branch_word_t w,
                                   output outcome_t o);
        logic [BTB_IW-1:0] bi;
        logic [PHT_IW-1:0] pi;
        bi = BTB_IW'(w.pc >> IDX_LSB);
        pi = PHT_IW'(w.pc >> IDX_LSB) ^ PHT_IW'(ghist);
        o  = '0;
        if (op == OP_PREDICT) begin
            o.hit        = btb[bi].valid && (btb[bi].tag == w.pc);
            o.use_target = o.hit && (!btb[bi].cond || pht[pi] >= CTR_TAKEN);
            o.next_pc    = o.use_target ? btb[bi].target : w.pc + PC_STEP;
        end else begin
            o.next_pc    = w.actual;
            o.mispredict = (w.actual != w.predicted) || (w.pred_taken != w.taken)
                           || (w.taken && !w.fetch_hit);
            // only taken branches allocate, replacing whatever was there
            if (w.taken) begin
                btb[bi].valid  = 1'b1;
                btb[bi].cond   = w.cond;
                btb[bi].tag    = w.pc;
                btb[bi].target = w.actual;
            end
            // counter trained with the old history, then history shifts
            if (w.cond) begin
                if (w.taken && pht[pi] != CTR_MAX)
                    pht[pi] = pht[pi] + 1'b1;
                else if (!w.taken && pht[pi] != '0)
                    pht[pi] = pht[pi] - 1'b1;
                ghist = {ghist[HIST_W-2:0], w.taken};
            end
        end
    endtask

    task automatic note_failure(input string what, input outcome_t want, input outcome_t got);
        fail_count++;
        if (fail_count <= SHOWN) begin
            $write("%0t %s: expected next_pc %h mispredict %b btb_hit %b taken %b",
                   $realtime, what, want.next_pc, want.mispredict, want.hit,
                   want.use_target);
            $display(", got next_pc %h mispredict %b btb_hit %b taken %b",
                     got.next_pc, got.mispredict, got.hit, got.use_target);
        end
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (!aresetn) begin
            ghist = '0;
            foreach (btb[i]) btb[i].valid = 1'b0;
            foreach (pht[i]) pht[i] = '0;
            outcome_q.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_outcome(opcode_t'(s_tuser),
                                branch_word_t'(s_tdata[$bits(branch_word_t)-1:0]), want);
                outcome_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
                if (outcome_q.size() == 0) begin
                    note_failure("unexpected word", '0, got);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.next_pc !== want.next_pc || got.mispredict !== want.mispredict
                        || got.hit !== want.hit || got.use_target !== want.use_target)
                        note_failure("mismatch", want, got);
                end
            end
        end
        pending <= outcome_q.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for the gshare / btb branch predictor
// Drives predict and resolve words: a directed opening, then loops, jumps,
// lookups and noise on a small set of branch addresses, with random gaps on
// both sides. The checker judges every result word.
// ============================================================================
module tb_top;
    import gsbp_pkg::*;

    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 625;
    localparam int POOL           = 16;
    // covers the reset sweep plus long stall runs with margin
    localparam int STUCK_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 16;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    int                    fail_count;
    int                    pending;

    logic                  idle_en = 1'b1;   // random gaps on both sides
    int                    words_sent = 0;
    int                    stuck_cycles = 0;
    logic [PC_W-1:0]       pool_pc  [POOL];
    logic [PC_W-1:0]       pool_tgt [POOL];

    always #5 aclk = ~aclk;

    gshare_btb_branch_predictor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gsbp_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side back-pressure, m_tready low about 20 percent of the time while gaps are on
    always @(negedge aclk) begin
        m_tready <= !(idle_en && $urandom_range(0, 99) < 20);
    end

    // any cycle without a handshake on either side counts toward the limit
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [PC_W-1:0] rand_pc();
        return {$urandom, $urandom};
    endfunction

    // one word: optional idle cycles, then hold valid until accepted
    task automatic send_word(input opcode_t op, input logic [PC_W-1:0] pc,
                             input logic [PC_W-1:0] actual, input logic [PC_W-1:0] predicted,
                             input logic cond, input logic taken,
                             input logic ptaken, input logic fhit);
        while (idle_en && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({fhit, ptaken, taken, cond, predicted, actual, pc});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    // the resolve-only fields are junk on a fetch lookup
    task automatic send_predict(input logic [PC_W-1:0] pc);
        send_word(OP_PREDICT, pc, rand_pc(), rand_pc(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // fetch-time guesses are right most of the time, wrong now and then
    task automatic send_resolve(input logic [PC_W-1:0] pc, input logic [PC_W-1:0] actual,
                                input logic cond, input logic taken);
        logic [PC_W-1:0] predicted;
        logic            ptaken;
        predicted = ($urandom_range(0, 3) == 0) ? rand_pc() : actual;
        ptaken    = ($urandom_range(0, 3) == 0) ? !taken : taken;
        send_word(OP_RESOLVE, pc, actual, predicted, cond, taken, ptaken,
                  $urandom_range(0, 3) != 0);
    endtask

    initial begin
        logic [PC_W-1:0] pc_a;
        logic [PC_W-1:0] pc_a2;
        logic [PC_W-1:0] pc_b;
        logic [PC_W-1:0] pc_c;
        logic [PC_W-1:0] tgt;
        int              k;
        int              pick;

        pc_a  = 64'h8000_0000_0040_0100;
        pc_a2 = pc_a ^ (64'h1 << 40);              // same btb slot, other tag
        pc_b  = 64'h0000_0000_0040_0204;
        pc_c  = 64'hFFFF_0000_0000_0ABC;
        tgt   = 64'h1234_5678_9ABC_DEF0;

        // branch addresses, a few of them aliasing others in the btb
        for (int i = 0; i < POOL; i++) begin
            pool_pc[i]  = rand_pc() & ~64'h3;
            pool_tgt[i] = rand_pc() & ~64'h3;
        end
        for (int i = 0; i < 4; i++)
            pool_pc[POOL-1-i] = pool_pc[i] ^ (64'h1 << $urandom_range(12, 63));

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed opening: empty btb lookups, including the pc+4 wrap
        send_predict('0);
        send_predict('1);
        // unconditional taken that missed at fetch, then a hit on it
        send_word(OP_RESOLVE, pc_a, '1, '1, 1'b0, 1'b1, 1'b1, 1'b0);
        send_predict(pc_a);
        // not taken: nothing allocated, so the lookup still misses
        send_word(OP_RESOLVE, pc_b, pc_b + 4, pc_b + 4, 1'b0, 1'b0, 1'b0, 1'b0);
        send_predict(pc_b);
        // wrong target only, new target written
        send_word(OP_RESOLVE, pc_a, '0, 64'h1, 1'b0, 1'b1, 1'b1, 1'b1);
        send_predict(pc_a);
        // wrong direction only; alias evicts the entry
        send_word(OP_RESOLVE, pc_a2, 64'h1, 64'h1, 1'b0, 1'b1, 1'b0, 1'b1);
        send_predict(pc_a);
        send_predict(pc_a2);
        // conditional not taken on a cleared counter stays at zero
        send_word(OP_RESOLVE, pc_c, pc_c + 4, pc_c + 4, 1'b1, 1'b0, 1'b0, 1'b0);
        // taken loop fills the history and trains its counter to weakly taken
        repeat (10) send_word(OP_RESOLVE, pc_c, tgt, tgt, 1'b1, 1'b1, 1'b1, 1'b1);
        send_predict(pc_c);
        send_word(OP_RESOLVE, pc_c, pc_c + 4, tgt, 1'b1, 1'b0, 1'b1, 1'b1);
        send_predict(pc_c);

        // random part
        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            idle_en <= !(words_sent >= 250 && words_sent < 400);
            k    = $urandom_range(0, POOL - 1);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // conditional loop: lookup and taken resolve, then the exit
                if ($urandom_range(0, 9) == 0)
                    pool_tgt[k] = rand_pc();
                repeat ($urandom_range(1, 12)) begin
                    send_predict(pool_pc[k]);
                    send_resolve(pool_pc[k], pool_tgt[k], 1'b1, 1'b1);
                end
                send_predict(pool_pc[k]);
                send_resolve(pool_pc[k], pool_pc[k] + 4, 1'b1, 1'b0);
            end else if (pick < 60) begin
                // jump or call, then the next fetch of it
                if ($urandom_range(0, 3) == 0)
                    pool_tgt[k] = rand_pc();
                send_resolve(pool_pc[k], pool_tgt[k], 1'b0, 1'b1);
                send_predict(pool_pc[k]);
            end else if (pick < 80) begin
                send_predict(pool_pc[k]);
            end else begin
                // noise: every field random, pc sometimes a known branch
                send_word(opcode_t'($urandom_range(0, 1)),
                          ($urandom_range(0, 1) == 1) ? pool_pc[k] : rand_pc(),
                          rand_pc(), rand_pc(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
        s_tvalid <= 1'b0;

        // drain, then give a stray word time to show up
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
